// ===== rtl/fcr_pkg.sv =====
// Shared constants, types and functions of the framed command responder.
package fcr_pkg;

	localparam int FRAME_BYTES = 150;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int REPLY_LEN   = 28;
	localparam int RIDX_W      = $clog2(REPLY_LEN);
	localparam int SUM_POS     = REPLY_LEN - 2;
	localparam int ID_POS      = 8;
	localparam int CMD_POS     = 13;
	localparam int CMD_POS_END = 15;

	localparam logic [7:0] CH_B  = 8'h42;
	localparam logic [7:0] CH_Z  = 8'h5A;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_0  = 8'h30;

	localparam logic       REQ_BYTE = 1'b0;
	localparam logic       REQ_TICK = 1'b1;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_CMD  = 3'd2;

	localparam logic [2:0] CMD_NONE = 3'd0;
	localparam logic [2:0] CMD_MAR  = 3'd1;
	localparam logic [2:0] CMD_STP  = 3'd2;
	localparam logic [2:0] CMD_STD  = 3'd3;

	localparam logic       REG_TIMEOUT = 1'b0;
	localparam logic       REG_OWN_ID  = 1'b1;

	typedef struct packed {
		logic take;
		logic walk_step;
		logic decide;
		logic reply_step;
	} ctrl_cmd_t;

	typedef struct packed {
		logic frame_done;
		logic walk_last;
		logic frame_ok;
		logic reply_last;
	} dp_status_t;

	function automatic logic [7:0] bump_sum(input logic [7:0] s);
		logic [7:0] r;
		r = s;
		if (s == CH_B || s == CH_Z || s == CH_LF) begin
			r = s + 8'd1;
		end
		return r;
	endfunction

	// Reply bytes other than the checksum, including the closing newline.
	function automatic logic [7:0] reply_byte(input logic [RIDX_W-1:0] k,
		input logic [23:0] id, input logic [2:0] err);
		logic [7:0] r;
		logic ok;
		ok = (err == ERR_NONE);
		case (k)
			5'd0:    r = CH_B;
			5'd1:    r = 8'h7C;
			5'd2:    r = 8'h20;
			5'd3:    r = id[23:16];
			5'd4:    r = id[15:8];
			5'd5:    r = id[7:0];
			5'd6:    r = 8'h7C;
			5'd7:    r = 8'h20;
			5'd8:    r = 8'h50;
			5'd9:    r = 8'h43;
			5'd10:   r = 8'h53;
			5'd11:   r = 8'h7C;
			5'd12:   r = 8'h20;
			5'd13:   r = ok ? 8'h41 : 8'h45;
			5'd14:   r = ok ? 8'h43 : 8'h52;
			5'd15:   r = ok ? 8'h4B : 8'h52;
			5'd16:   r = CH_0;
			5'd17:   r = 8'h00;
			5'd18:   r = CH_0;
			5'd19:   r = CH_0;
			5'd20:   r = CH_0 + {5'd0, err};
			5'd21:   r = 8'h7C;
			5'd22:   r = 8'h20;
			5'd23:   r = CH_Z;
			5'd24:   r = 8'h7C;
			5'd25:   r = 8'h20;
			default: r = CH_LF;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/fcr_req_if.sv =====
// Input channel: received bytes and timer ticks.
interface fcr_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] rx_byte;
	logic [2:0] fault_switch;

	modport source (output valid, req_type, rx_byte, fault_switch, input ready);
	modport sink   (input valid, req_type, rx_byte, fault_switch, output ready);
endinterface

// ===== rtl/fcr_rsp_if.sv =====
// Output channel: reply bytes with status.
interface fcr_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;
	logic       running;
	logic [2:0] report_code;

	modport source (output valid, tx_byte, last_byte, running, report_code, input ready);
	modport sink   (input valid, tx_byte, last_byte, running, report_code, output ready);
endinterface

// ===== rtl/fcr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module fcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 150
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== rtl/fcr_datapath.sv =====
// Frame capture, checksum walk, command decode and reply byte generation.
module fcr_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fcr_pkg::ctrl_cmd_t     cmd,
	output fcr_pkg::dp_status_t    status,
	input  logic                   req_type,
	input  logic [7:0]             rx_byte,
	input  logic [2:0]             fault_switch,
	input  logic [7:0]             timeout_ticks,
	input  logic [23:0]            own_id,
	output logic [7:0]             tx_byte,
	output logic                   last_byte,
	output logic                   running,
	output logic [2:0]             report_code
);
	localparam logic [fcr_pkg::IDX_W-1:0] LAST_IDX =
		fcr_pkg::IDX_W'(fcr_pkg::FRAME_BYTES - 1);

	logic                            receiving_q;
	logic [fcr_pkg::IDX_W-1:0]       wr_idx_q, end_idx_q, len_q, rd_addr_q, rd_addr_s1;
	logic [7:0]                      tick_q, sum_q, chk_q, rsum_q;
	logic [fcr_pkg::FRAME_BYTES-1:0] valid_q;
	logic                            rd_pend_s1, rd_vld_s1, run_q;
	logic [2:0]                      fault_q, err_q;
	logic [7:0]                      id_q [3];
	logic [7:0]                      cmd_q [3];
	logic [fcr_pkg::RIDX_W-1:0]      rep_idx_q;

	logic [fcr_pkg::IDX_W-1:0]       wi_nx, end_nx, walk_end;
	logic [fcr_pkg::IDX_W:0]         end_sum;
	logic                            is_byte, start_b, done;
	logic                            wr_en;
	logic [fcr_pkg::IDX_W-1:0]       wr_addr;
	logic [7:0]                      rd_data, rd_byte;
	logic [2:0]                      cmd_code, err_nx;
	logic                            run_nx, ok;

	assign is_byte = (req_type == fcr_pkg::REQ_BYTE);
	assign start_b = is_byte && !receiving_q && (rx_byte == fcr_pkg::CH_B);
	assign wi_nx   = wr_idx_q + 1'b1;
	assign end_sum = {1'b0, wi_nx} + (fcr_pkg::IDX_W + 1)'(3);
	always_comb begin
		end_nx = end_idx_q;
		if (rx_byte == fcr_pkg::CH_Z) begin
			end_nx = (end_sum > {1'b0, LAST_IDX}) ? LAST_IDX
				: end_sum[fcr_pkg::IDX_W-1:0];
		end
	end
	assign done    = is_byte && receiving_q && (wi_nx >= end_nx);
	assign wr_en   = cmd.take && is_byte && (receiving_q || start_b);
	assign wr_addr = receiving_q ? wi_nx : '0;

	fcr_ram #(.WIDTH(8), .DEPTH(fcr_pkg::FRAME_BYTES)) u_store (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(rx_byte),
		.rd_addr(rd_addr_q), .rd_data(rd_data)
	);

	assign rd_byte  = rd_vld_s1 ? rd_data : 8'd0;
	assign walk_end = (len_q > fcr_pkg::IDX_W'(fcr_pkg::CMD_POS_END)) ? len_q
		: fcr_pkg::IDX_W'(fcr_pkg::CMD_POS_END);

	always_comb begin
		cmd_code = fcr_pkg::CMD_NONE;
		if (cmd_q[0] == 8'h4D && cmd_q[1] == 8'h41 && cmd_q[2] == 8'h52) begin
			cmd_code = fcr_pkg::CMD_MAR;
		end else if (cmd_q[0] == 8'h53 && cmd_q[1] == 8'h54 && cmd_q[2] == 8'h50) begin
			cmd_code = fcr_pkg::CMD_STP;
		end else if (cmd_q[0] == 8'h53 && cmd_q[1] == 8'h54 && cmd_q[2] == 8'h44) begin
			cmd_code = fcr_pkg::CMD_STD;
		end
		err_nx = (cmd_code == fcr_pkg::CMD_NONE) ? fcr_pkg::ERR_CMD : fault_q;
		run_nx = run_q;
		if (err_nx == fcr_pkg::ERR_NONE) begin
			case (cmd_code)
				fcr_pkg::CMD_MAR: run_nx = 1'b1;
				fcr_pkg::CMD_STP: run_nx = 1'b0;
				default: begin
					if (!run_q) begin
						err_nx = fcr_pkg::ERR_CMD;
					end
				end
			endcase
		end
	end

	assign ok = (fcr_pkg::bump_sum(sum_q) == chk_q) && (id_q[0] == own_id[23:16])
		&& (id_q[1] == own_id[15:8]) && (id_q[2] == own_id[7:0]);

	always_comb begin
		if (rep_idx_q == fcr_pkg::RIDX_W'(fcr_pkg::SUM_POS)) begin
			tx_byte = fcr_pkg::bump_sum(rsum_q);
		end else begin
			tx_byte = fcr_pkg::reply_byte(rep_idx_q, own_id, err_q);
		end
	end
	assign last_byte   = (rep_idx_q == fcr_pkg::RIDX_W'(fcr_pkg::REPLY_LEN - 1));
	assign running     = run_q;
	assign report_code = err_q;

	assign status.frame_done = done;
	assign status.walk_last  = (rd_addr_q == walk_end);
	assign status.frame_ok   = ok;
	assign status.reply_last = last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			wr_idx_q    <= '0;
			end_idx_q   <= LAST_IDX;
			tick_q      <= '0;
			run_q       <= 1'b0;
			valid_q     <= '0;
			rd_pend_s1  <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.walk_step;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.take) begin
				if (!is_byte) begin
					if (receiving_q) begin
						if (tick_q == timeout_ticks) begin
							receiving_q <= 1'b0;
							end_idx_q   <= LAST_IDX;
						end
						tick_q <= tick_q + 8'd1;
					end else begin
						tick_q <= '0;
					end
				end else if (!receiving_q) begin
					if (start_b) begin
						receiving_q <= 1'b1;
						wr_idx_q    <= '0;
					end
				end else if (done) begin
					receiving_q <= 1'b0;
					wr_idx_q    <= '0;
					end_idx_q   <= LAST_IDX;
				end else begin
					wr_idx_q  <= wi_nx;
					end_idx_q <= end_nx;
				end
			end
			if (cmd.decide && ok) begin
				run_q <= run_nx;
			end
		end
	end

	// Walk and reply registers carry payload only.
	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr_q;
		rd_vld_s1  <= valid_q[rd_addr_q];
		if (cmd.take && done) begin
			len_q     <= end_nx;
			fault_q   <= fault_switch;
			rd_addr_q <= '0;
			sum_q     <= '0;
		end
		if (cmd.walk_step) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (rd_pend_s1) begin
			if (rd_addr_s1 < len_q) begin
				sum_q <= sum_q + rd_byte;
			end
			if (rd_addr_s1 == len_q) begin
				chk_q <= rd_byte;
			end
			for (int i = 0; i < 3; i++) begin
				if (rd_addr_s1 == fcr_pkg::IDX_W'(fcr_pkg::ID_POS + i)) begin
					id_q[i] <= rd_byte;
				end
				if (rd_addr_s1 == fcr_pkg::IDX_W'(fcr_pkg::CMD_POS + i)) begin
					cmd_q[i] <= rd_byte;
				end
			end
		end
		if (cmd.decide) begin
			err_q     <= err_nx;
			rep_idx_q <= '0;
			rsum_q    <= '0;
		end
		if (cmd.reply_step) begin
			rep_idx_q <= rep_idx_q + 1'b1;
			rsum_q    <= rsum_q + tx_byte;
		end
	end
endmodule

// ===== rtl/fcr_controller.sv =====
// Sequencer: receive, checksum walk, decision and reply emission.
module fcr_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  fcr_pkg::dp_status_t status,
	output fcr_pkg::ctrl_cmd_t  cmd
);
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WALK   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_REPLY  = 5'b10000
	} state_t;

	state_t state_q, state_nx;

	always_comb begin
		state_nx       = state_q;
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && status.frame_done) begin
					state_nx = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nx = ST_DECIDE;
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_nx   = status.frame_ok ? ST_REPLY : ST_IDLE;
			end
			ST_REPLY: begin
				out_valid      = 1'b1;
				cmd.reply_step = out_ready;
				if (out_ready && status.reply_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end
endmodule

// ===== rtl/framed_command_responder.sv =====
// Top level of the framed command responder with its APB register port.
//
// The block takes one transfer per received byte or timer tick and answers
// each accepted frame with 28 reply transfers, ending on the newline byte.
// The byte that closes a frame starts a checksum walk over the frame store,
// one memory read per cycle over max(length, 15) + 1 addresses, followed by
// a drain state and a decision state; the reply then moves one byte per
// cycle while the sink is ready. Input is not accepted during the walk, the
// drain, the decision or the reply. No clearing pass runs after reset: the
// store has a valid bit per entry, and an entry never written reads as zero.
module framed_command_responder (
	input  logic          clk,
	input  logic          arst_n,
	fcr_req_if.sink       req,
	fcr_rsp_if.source     rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	fcr_pkg::ctrl_cmd_t  cmd;
	fcr_pkg::dp_status_t status;
	logic [7:0]          timeout_q;
	logic [23:0]         own_id_q;
	logic                reg_sel;

	// Registers sit at byte addresses 0 and 4; bit 2 picks the register.
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_sel == fcr_pkg::REG_OWN_ID) ? {8'd0, own_id_q}
		: {24'd0, timeout_q};

	// Configuration is written during the access phase of an APB write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 8'd200;
			own_id_q  <= 24'h474452;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == fcr_pkg::REG_TIMEOUT) begin
				timeout_q <= pwdata[7:0];
			end else begin
				own_id_q <= pwdata[23:0];
			end
		end
	end

	// The controller owns the handshakes; the datapath owns the frame, walk and reply state.
	fcr_controller u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.status(status), .cmd(cmd)
	);

	fcr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.req_type(req.req_type), .rx_byte(req.rx_byte),
		.fault_switch(req.fault_switch),
		.timeout_ticks(timeout_q), .own_id(own_id_q),
		.tx_byte(rsp.tx_byte), .last_byte(rsp.last_byte),
		.running(rsp.running), .report_code(rsp.report_code)
	);
endmodule

// ===== rtl/fcr_checker.sv =====
// Port-level assertions for the framed command responder and their binding.
module fcr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic       last_byte,
	input logic       running,
	input logic [2:0] report_code
);
	a_no_input_during_reply: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken during reply");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_byte |=> !out_valid)
		else $error("reply continues past last byte");

	a_status_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(out_ready && last_byte) |=>
		out_valid && $stable(running) && $stable(report_code))
		else $error("reply status changed mid-frame");

	a_last_is_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |-> tx_byte == 8'd10)
		else $error("last reply byte is not a newline");
endmodule

bind framed_command_responder fcr_checker u_fcr_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .tx_byte(rsp.tx_byte),
	.last_byte(rsp.last_byte), .running(rsp.running), .report_code(rsp.report_code)
);
